// File: hw/rtl/ctt_pkg.sv
`timescale 1ns / 1ps

package ctt_pkg;

   localparam int unsigned TABLE_ENTRIES_DEFAULT = 64;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;

   // Minimum frame lengths: Ethernet header, IPv4 header, TCP header, UDP header
   localparam logic [15:0] LEN_ETH_END = 16'd14;
   localparam logic [15:0] LEN_IP_END  = 16'd34;
   localparam logic [15:0] LEN_TCP_END = 16'd54;
   localparam logic [15:0] LEN_UDP_END = 16'd42;

   typedef enum logic [2:0] {
      CLS_ERROR   = 3'd0,
      CLS_NOFLAGS = 3'd1,
      CLS_NOTTCP  = 3'd2,
      CLS_SYN     = 3'd3,
      CLS_SYNACK  = 3'd4,
      CLS_ACK     = 3'd5,
      CLS_FIN     = 3'd6,
      CLS_UDP     = 3'd7
   } frame_class_type;

   typedef struct packed {
      logic ack;
      logic synack;
      logic syn;
   } seen_type;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  proto;
   } conn_key_type;

   typedef struct packed {
      conn_key_type key;
      seen_type     bits;
   } lookup_req_type;

   typedef struct packed {
      logic     touched;
      logic     created;
      logic     dropped;
      seen_type seen;
   } lookup_status_type;

endpackage

// File: hw/rtl/ctt_lookup.sv
`timescale 1ns / 1ps

module ctt_lookup
   import ctt_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  lookup_req_type    req,
   output logic              done,
   output lookup_status_type status
);

   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] TABLE_FULL = CNT_W'(TABLE_ENTRIES);

   typedef struct packed {
      conn_key_type key;
      seen_type     flags;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   entry_type entry_mem [TABLE_ENTRIES];

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   conn_key_type      key_ff, key_in;
   seen_type          bits_ff, bits_in;
   logic              done_ff, done_in;
   lookup_status_type status_ff, status_in;
   entry_type         rd_data_ff;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;
   logic              match;

   assign match = rd_pend_ff && (rd_data_ff.key == key_ff);

   always_comb begin
      state_in   = state_ff;
      used_in    = used_ff;
      issue_in   = issue_ff;
      rd_pend_in = 1'b0;
      rd_idx_in  = rd_idx_ff;
      hit_in     = hit_ff;
      hit_idx_in = hit_idx_ff;
      key_in     = key_ff;
      bits_in    = bits_ff;
      done_in    = 1'b0;
      status_in  = status_ff;
      rd_en      = 1'b0;
      rd_addr    = issue_ff[IDX_W-1:0];
      wr_en      = 1'b0;
      wr_addr    = used_ff[IDX_W-1:0];
      wr_data    = '{key: key_ff, flags: bits_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (go) begin
               key_in   = req.key;
               bits_in  = req.bits;
               issue_in = '0;
               hit_in   = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // one compare per cycle against the entry read in the previous cycle
            if (match) begin
               hit_in     = 1'b1;
               hit_idx_in = rd_idx_ff;
               state_in   = ST_UPDATE;
            end else if (issue_ff < used_ff) begin
               rd_en      = 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in  = issue_ff[IDX_W-1:0];
               issue_in   = issue_ff + 1'b1;
            end else if (!rd_pend_ff) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            status_in = '0;
            if (hit_ff) begin
               // merge bits into the matched entry still held in the read register
               wr_en             = 1'b1;
               wr_addr           = hit_idx_ff;
               wr_data.flags     = rd_data_ff.flags | bits_ff;
               status_in.touched = 1'b1;
               status_in.seen    = rd_data_ff.flags | bits_ff;
            end else if (used_ff < TABLE_FULL) begin
               // slots fill in order, so the next free slot is the fill count
               wr_en             = 1'b1;
               used_in           = used_ff + 1'b1;
               status_in.touched = 1'b1;
               status_in.created = 1'b1;
               status_in.seen    = bits_ff;
            end else begin
               status_in.dropped = 1'b1;
            end
            done_in  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      issue_ff   <= issue_in;
      rd_idx_ff  <= rd_idx_in;
      hit_ff     <= hit_in;
      hit_idx_ff <= hit_idx_in;
      key_ff     <= key_in;
      bits_ff    <= bits_in;
      status_ff  <= status_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         used_ff    <= '0;
         rd_pend_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         used_ff    <= used_in;
         rd_pend_ff <= rd_pend_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign done   = done_ff;
   assign status = status_ff;

endmodule

// File: hw/rtl/tcp_udp_connection_tracker.sv
`timescale 1ns / 1ps

// Channel   Ports                          Handshake
// request   start, busy, req_*             taken when start and not busy
// result    rsp_valid, rsp_*               one-cycle strobe, no back-pressure
// config    csr_psel/penable/pwrite/...    APB, written in access phase, pready tied high
//
// An untracked frame (error, no flags, not TCP, UDP on transmit) returns its result
// in the cycle after it is taken and busy never rises.
// A tracked frame scans the filled entries of the table one per cycle through a single
// key comparator, stopping at the first entry whose key matches.
// Reset empties the table at once through the fill count and sets forwarding on.
// The receiver cannot stall; busy is high from a tracked item until its result.

module tcp_udp_connection_tracker
   import ctt_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [15:0] req_frame_length,
   input  logic [15:0] req_ethertype,
   input  logic [7:0]  req_ip_protocol,
   input  logic [31:0] req_source_address,
   input  logic [31:0] req_dest_address,
   input  logic [15:0] req_source_port_number,
   input  logic [15:0] req_dest_port_number,
   input  logic        req_fin_bit,
   input  logic        req_syn_bit,
   input  logic        req_ack_bit,
   input  logic [7:0]  req_ingress_port,

   output logic        rsp_valid,
   output logic [2:0]  rsp_frame_class,
   output logic        rsp_action,
   output logic [7:0]  rsp_egress_port,
   output logic        rsp_table_touched,
   output logic        rsp_entry_created,
   output logic        rsp_table_full_drop,
   output logic        rsp_seen_syn,
   output logic        rsp_seen_synack,
   output logic        rsp_seen_ack,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic CSR_FORWARDING_ENABLED = 1'b0;

   frame_class_type   cls;
   logic              tracked;
   seen_type          bits;
   lookup_req_type    lk_req;
   logic              lk_go;
   logic              lk_done;
   lookup_status_type lk_status;
   logic              accept;
   logic              csr_write;

   logic              busy_ff, busy_in;
   logic              fwd_ff, fwd_in;
   frame_class_type   class_ff, class_in;
   logic [7:0]        port_ff, port_in;
   logic              rsp_valid_ff, rsp_valid_in;
   frame_class_type   rsp_class_ff, rsp_class_in;
   logic              rsp_action_ff, rsp_action_in;
   logic [7:0]        rsp_egress_ff, rsp_egress_in;
   lookup_status_type rsp_status_ff, rsp_status_in;

   assign accept    = start && !busy_ff;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      if (req_frame_length < LEN_ETH_END) begin
         cls = CLS_ERROR;
      end else if (req_ethertype != ETHERTYPE_IPV4) begin
         cls = CLS_NOTTCP;
      end else if (req_frame_length < LEN_IP_END) begin
         cls = CLS_ERROR;
      end else if (req_ip_protocol == PROTO_TCP) begin
         if (req_frame_length < LEN_TCP_END) begin
            cls = CLS_ERROR;
         end else if (req_fin_bit) begin
            cls = CLS_FIN;
         end else if (req_syn_bit && !req_ack_bit) begin
            cls = CLS_SYN;
         end else if (req_syn_bit) begin
            cls = CLS_SYNACK;
         end else if (req_ack_bit) begin
            cls = CLS_ACK;
         end else begin
            cls = CLS_NOFLAGS;
         end
      end else if (req_ip_protocol == PROTO_UDP) begin
         cls = (req_frame_length < LEN_UDP_END) ? CLS_ERROR : CLS_UDP;
      end else begin
         cls = CLS_NOTTCP;
      end
   end

   always_comb begin
      bits    = '0;
      tracked = 1'b0;
      case (cls) inside
         CLS_SYN: begin
            bits.syn = 1'b1;
            tracked  = 1'b1;
         end
         CLS_SYNACK: begin
            bits.synack = 1'b1;
            tracked     = 1'b1;
         end
         CLS_ACK: begin
            bits.ack = 1'b1;
            tracked  = 1'b1;
         end
         CLS_FIN: begin
            tracked = 1'b1;
         end
         CLS_UDP: begin
            bits    = '1;
            tracked = !req_kind;
         end
         CLS_ERROR, CLS_NOFLAGS, CLS_NOTTCP: begin
            tracked = 1'b0;
         end
         default: begin
            tracked = 1'b0;
         end
      endcase
   end

   // swap the tuple on transmit so both directions share one entry
   always_comb begin
      lk_req.bits       = bits;
      lk_req.key.proto  = req_ip_protocol;
      if (req_kind) begin
         lk_req.key.src_addr = req_dest_address;
         lk_req.key.dst_addr = req_source_address;
         lk_req.key.sport    = req_dest_port_number;
         lk_req.key.dport    = req_source_port_number;
      end else begin
         lk_req.key.src_addr = req_source_address;
         lk_req.key.dst_addr = req_dest_address;
         lk_req.key.sport    = req_source_port_number;
         lk_req.key.dport    = req_dest_port_number;
      end
   end

   assign lk_go = accept && tracked;

   ctt_lookup #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_lookup (
      .clock (clock),
      .reset (reset),
      .go    (lk_go),
      .req   (lk_req),
      .done  (lk_done),
      .status(lk_status)
   );

   always_comb begin
      busy_in       = busy_ff;
      fwd_in        = fwd_ff;
      class_in      = class_ff;
      port_in       = port_ff;
      rsp_valid_in  = 1'b0;
      rsp_class_in  = rsp_class_ff;
      rsp_action_in = rsp_action_ff;
      rsp_egress_in = rsp_egress_ff;
      rsp_status_in = rsp_status_ff;

      if (csr_write && (csr_paddr[2] == CSR_FORWARDING_ENABLED)) begin
         fwd_in = csr_pwdata[0];
      end

      if (accept) begin
         class_in = cls;
         port_in  = req_ingress_port;
         if (tracked) begin
            busy_in = 1'b1;
         end else begin
            rsp_valid_in  = 1'b1;
            rsp_class_in  = cls;
            rsp_action_in = fwd_ff;
            rsp_egress_in = fwd_ff ? req_ingress_port : 8'd0;
            rsp_status_in = '0;
         end
      end else if (lk_done) begin
         busy_in       = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_class_in  = class_ff;
         rsp_action_in = fwd_ff;
         rsp_egress_in = fwd_ff ? port_ff : 8'd0;
         rsp_status_in = lk_status;
      end
   end

   always_ff @(posedge clock) begin
      class_ff      <= class_in;
      port_ff       <= port_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_action_ff <= rsp_action_in;
      rsp_egress_ff <= rsp_egress_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         busy_ff      <= 1'b0;
         fwd_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy                = busy_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_class     = rsp_class_ff;
   assign rsp_action          = rsp_action_ff;
   assign rsp_egress_port     = rsp_egress_ff;
   assign rsp_table_touched   = rsp_status_ff.touched;
   assign rsp_entry_created   = rsp_status_ff.created;
   assign rsp_table_full_drop = rsp_status_ff.dropped;
   assign rsp_seen_syn        = rsp_status_ff.seen.syn;
   assign rsp_seen_synack     = rsp_status_ff.seen.synack;
   assign rsp_seen_ack        = rsp_status_ff.seen.ack;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_FORWARDING_ENABLED) ? {31'd0, fwd_ff} : 32'd0;

endmodule

// File: tb/tcp_udp_connection_tracker_tb.sv
`timescale 1ns / 1ps

module tcp_udp_connection_tracker_tb;
   import ctt_pkg::*;

   localparam int unsigned ENTRIES         = TABLE_ENTRIES_DEFAULT;
   localparam logic [2:0]  ADDR_FORWARDING = 3'd0;
   localparam int unsigned POOL_SIZE       = 40;
   localparam int unsigned ITEMS_PER_PHASE = 460;
   localparam int unsigned CYCLE_LIMIT     = 600000;
   localparam int unsigned MAX_PRINTED     = 40;
   localparam int unsigned SCAN_CYCLES     = ENTRIES + 8;

   typedef struct {
      logic        dir;
      logic [15:0] length;
      logic [15:0] etype;
      logic [7:0]  proto;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] sport;
      logic [15:0] dport;
      logic        fin;
      logic        syn;
      logic        ack;
      logic [7:0]  ingress;
   } frame_item_type;

   typedef struct {
      frame_class_type cls;
      logic            action;
      logic [7:0]      egress;
      logic            touched;
      logic            created;
      logic            dropped;
      seen_type        seen;
   } verdict_type;

   class conn_table_predictor;
      conn_key_type keys  [ENTRIES];
      seen_type     flags [ENTRIES];
      bit           valid [ENTRIES];
      int unsigned  used;
      bit           forwarding = 1'b1;
      verdict_type  pending_verdicts[$];
      int unsigned  mismatches, checked, inserts, merges, drops;

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= MAX_PRINTED) $display("[%0t] MISMATCH: %s", $time, msg);
      endtask

      function frame_class_type classify(frame_item_type f);
         if (f.length < LEN_ETH_END) return CLS_ERROR;
         if (f.etype != ETHERTYPE_IPV4) return CLS_NOTTCP;
         if (f.length < LEN_IP_END) return CLS_ERROR;
         if (f.proto == PROTO_TCP) begin
            if (f.length < LEN_TCP_END) return CLS_ERROR;
            if (f.fin) return CLS_FIN;
            if (f.syn) return f.ack ? CLS_SYNACK : CLS_SYN;
            if (f.ack) return CLS_ACK;
            return CLS_NOFLAGS;
         end
         if (f.proto == PROTO_UDP) return (f.length < LEN_UDP_END) ? CLS_ERROR : CLS_UDP;
         return CLS_NOTTCP;
      endfunction

      function void take_frame(frame_item_type f);
         verdict_type  v;
         conn_key_type key;
         seen_type     bits;
         int           hit;
         int           slot;
         v.cls     = classify(f);
         v.action  = forwarding;
         v.egress  = forwarding ? f.ingress : 8'd0;
         v.touched = 1'b0;
         v.created = 1'b0;
         v.dropped = 1'b0;
         v.seen    = '0;
         if (v.cls == CLS_SYN || v.cls == CLS_SYNACK || v.cls == CLS_ACK ||
             v.cls == CLS_FIN || (v.cls == CLS_UDP && !f.dir)) begin
            // transmit frames are looked up from the peer's point of view
            key.src_addr = f.dir ? f.dst_addr : f.src_addr;
            key.dst_addr = f.dir ? f.src_addr : f.dst_addr;
            key.sport    = f.dir ? f.dport : f.sport;
            key.dport    = f.dir ? f.sport : f.dport;
            key.proto    = f.proto;
            bits = '0;
            case (v.cls)
               CLS_UDP:    bits = '1;
               CLS_SYN:    bits.syn = 1'b1;
               CLS_SYNACK: bits.synack = 1'b1;
               CLS_ACK:    bits.ack = 1'b1;
               default:    bits = '0;
            endcase
            hit = -1;
            for (int i = 0; i < ENTRIES; i++)
               if (hit < 0 && valid[i] && keys[i] == key) hit = i;
            if (hit >= 0) begin
               flags[hit] = seen_type'(flags[hit] | bits);
               v.seen     = flags[hit];
               v.touched  = 1'b1;
               merges++;
            end else begin
               slot = -1;
               if (used < ENTRIES)
                  for (int i = 0; i < ENTRIES; i++)
                     if (slot < 0 && !valid[i]) slot = i;
               if (slot >= 0) begin
                  valid[slot] = 1'b1;
                  keys[slot]  = key;
                  flags[slot] = bits;
                  used++;
                  v.seen    = bits;
                  v.touched = 1'b1;
                  v.created = 1'b1;
                  inserts++;
               end else begin
                  v.dropped = 1'b1;
                  drops++;
               end
            end
         end
         pending_verdicts.push_back(v);
      endfunction

      task check_verdict(verdict_type got);
         verdict_type want;
         if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("result with no frame waiting, class %0d", got.cls));
            return;
         end
         want = pending_verdicts.pop_front();
         checked++;
         if (got.cls !== want.cls)
            report_mismatch($sformatf("frame_class got %0d want %0d", got.cls, want.cls));
         if (got.action !== want.action)
            report_mismatch($sformatf("action got %0b want %0b", got.action, want.action));
         if (got.egress !== want.egress)
            report_mismatch($sformatf("egress_port got %0d want %0d", got.egress, want.egress));
         if (got.touched !== want.touched)
            report_mismatch($sformatf("table_touched got %0b want %0b",
                                      got.touched, want.touched));
         if (got.created !== want.created)
            report_mismatch($sformatf("entry_created got %0b want %0b",
                                      got.created, want.created));
         if (got.dropped !== want.dropped)
            report_mismatch($sformatf("table_full_drop got %0b want %0b",
                                      got.dropped, want.dropped));
         if (got.seen.syn !== want.seen.syn)
            report_mismatch($sformatf("seen_syn got %0b want %0b",
                                      got.seen.syn, want.seen.syn));
         if (got.seen.synack !== want.seen.synack)
            report_mismatch($sformatf("seen_synack got %0b want %0b",
                                      got.seen.synack, want.seen.synack));
         if (got.seen.ack !== want.seen.ack)
            report_mismatch($sformatf("seen_ack got %0b want %0b",
                                      got.seen.ack, want.seen.ack));
      endtask
   endclass

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           start = 1'b0;
   logic           busy;
   frame_item_type req_item = '{default: '0};

   logic        rsp_valid;
   logic [2:0]  rsp_frame_class;
   logic        rsp_action;
   logic [7:0]  rsp_egress_port;
   logic        rsp_table_touched;
   logic        rsp_entry_created;
   logic        rsp_table_full_drop;
   logic        rsp_seen_syn;
   logic        rsp_seen_synack;
   logic        rsp_seen_ack;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   conn_table_predictor tracker_model = new();
   conn_key_type        key_pool[POOL_SIZE];
   int unsigned         sender_idle;
   int unsigned         frames_sent;
   int unsigned         settings_used;
   int unsigned         cycle_count;

   tcp_udp_connection_tracker dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_kind               (req_item.dir),
      .req_frame_length       (req_item.length),
      .req_ethertype          (req_item.etype),
      .req_ip_protocol        (req_item.proto),
      .req_source_address     (req_item.src_addr),
      .req_dest_address       (req_item.dst_addr),
      .req_source_port_number (req_item.sport),
      .req_dest_port_number   (req_item.dport),
      .req_fin_bit            (req_item.fin),
      .req_syn_bit            (req_item.syn),
      .req_ack_bit            (req_item.ack),
      .req_ingress_port       (req_item.ingress),
      .rsp_valid              (rsp_valid),
      .rsp_frame_class        (rsp_frame_class),
      .rsp_action             (rsp_action),
      .rsp_egress_port        (rsp_egress_port),
      .rsp_table_touched      (rsp_table_touched),
      .rsp_entry_created      (rsp_entry_created),
      .rsp_table_full_drop    (rsp_table_full_drop),
      .rsp_seen_syn           (rsp_seen_syn),
      .rsp_seen_synack        (rsp_seen_synack),
      .rsp_seen_ack           (rsp_seen_ack),
      .csr_psel               (csr_psel),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_paddr              (csr_paddr),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata),
      .csr_pready             (csr_pready)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // check results before noting a new item: a result never belongs to the item
   // taken at the same edge
   always @(posedge clock) begin : monitor
      verdict_type got;
      if (!reset) begin
         if (rsp_valid) begin
            got.cls         = frame_class_type'(rsp_frame_class);
            got.action      = rsp_action;
            got.egress      = rsp_egress_port;
            got.touched     = rsp_table_touched;
            got.created     = rsp_entry_created;
            got.dropped     = rsp_table_full_drop;
            got.seen.syn    = rsp_seen_syn;
            got.seen.synack = rsp_seen_synack;
            got.seen.ack    = rsp_seen_ack;
            tracker_model.check_verdict(got);
         end
         if (start && !busy) tracker_model.take_frame(req_item);
      end
   end

   function automatic conn_key_type rand_key(logic [7:0] proto);
      conn_key_type k;
      k.src_addr = $urandom;
      k.dst_addr = $urandom;
      k.sport    = 16'($urandom_range(65535));
      k.dport    = 16'($urandom_range(65535));
      k.proto    = proto;
      return k;
   endfunction

   function automatic frame_item_type frame_for_key(conn_key_type k, logic dir, logic fin,
                                                    logic syn, logic ack);
      frame_item_type f;
      f.dir      = dir;
      f.length   = 16'($urandom_range(1514,
                                      (k.proto == PROTO_UDP) ? LEN_UDP_END : LEN_TCP_END));
      f.etype    = ETHERTYPE_IPV4;
      f.proto    = k.proto;
      f.src_addr = dir ? k.dst_addr : k.src_addr;
      f.dst_addr = dir ? k.src_addr : k.dst_addr;
      f.sport    = dir ? k.dport : k.sport;
      f.dport    = dir ? k.sport : k.dport;
      f.fin      = fin;
      f.syn      = syn;
      f.ack      = ack;
      f.ingress  = 8'($urandom_range(255));
      return f;
   endfunction

   function automatic frame_item_type random_frame();
      frame_item_type f;
      conn_key_type   k;
      int unsigned    pick;
      k = ($urandom_range(99) < 8) ?
          rand_key(($urandom_range(3) == 0) ? PROTO_UDP : PROTO_TCP) :
          key_pool[$urandom_range(POOL_SIZE - 1)];
      if ($urandom_range(99) < 75) begin
         // handshake step on a pooled or fresh connection
         pick = $urandom_range(99);
         if (k.proto == PROTO_UDP)
            f = frame_for_key(k, $urandom_range(99) < 20, 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
         else if (pick < 8)
            f = frame_for_key(k, 1'($urandom_range(1)), 1'b1, 1'($urandom_range(1)),
                              1'($urandom_range(1)));
         else
            f = frame_for_key(k, $urandom_range(99) < 35, 1'b0,
                              pick < 58, pick >= 33 && pick < 90);
         if ($urandom_range(9) == 0) f.length = 16'($urandom_range(65535, f.length));
      end else begin
         // malformed or foreign frames
         f = frame_for_key(k, 1'($urandom_range(1)), 1'($urandom_range(1)),
                           1'($urandom_range(1)), 1'($urandom_range(1)));
         f.length = $urandom_range(1) ? 16'($urandom_range(60)) : 16'($urandom_range(65535));
         if ($urandom_range(3) == 0) f.etype = 16'($urandom_range(65535));
         case ($urandom_range(3))
            0: f.proto = 8'($urandom_range(255));
            1: f.proto = PROTO_TCP;
            2: f.proto = PROTO_UDP;
            default: f.proto = k.proto;
         endcase
      end
      return f;
   endfunction

   task automatic send_frame(frame_item_type f);
      while ($urandom_range(99) < sender_idle) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_item <= f;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      frames_sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (tracker_model.pending_verdicts.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_access(logic write, logic [2:0] addr, logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_forwarding(bit on);
      logic [31:0] rd;
      csr_access(1'b1, ADDR_FORWARDING, {31'd0, on}, rd);
      tracker_model.forwarding = on;
      settings_used++;
      csr_access(1'b0, ADDR_FORWARDING, '0, rd);
      if (rd[0] !== on)
         tracker_model.report_mismatch($sformatf("forwarding read back %0b want %0b", rd[0], on));
   endtask

   initial begin
      frame_item_type f;
      conn_key_type   ka, kb, kc, kd, kedge;
      int unsigned    phase_idle[3];
      bit             phase_fwd[3];
      phase_idle = '{19, 65, 0};
      phase_fwd  = '{1'b1, 1'b0, 1'b1};
      foreach (key_pool[i])
         key_pool[i] = rand_key(($urandom_range(3) == 0) ? PROTO_UDP : PROTO_TCP);
      ka = rand_key(PROTO_TCP);
      kb = rand_key(PROTO_TCP);
      kc = rand_key(PROTO_UDP);
      kd = rand_key(PROTO_UDP);
      sender_idle = 19;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_forwarding(1'b0);

      // length and ethertype boundaries
      f = frame_for_key(ka, 1'b0, 1'b0, 1'b1, 1'b0);
      f.length = 16'd0;
      send_frame(f);
      f.length = LEN_ETH_END - 16'd1;
      send_frame(f);
      f.length = LEN_ETH_END;
      f.etype  = 16'h86DD;
      send_frame(f);
      f.etype  = ETHERTYPE_IPV4;
      f.length = LEN_IP_END - 16'd1;
      send_frame(f);
      f.length = LEN_IP_END;
      f.proto  = 8'd1;
      send_frame(f);
      f.proto  = PROTO_TCP;
      f.length = LEN_TCP_END - 16'd1;
      send_frame(f);
      f = frame_for_key(ka, 1'b0, 1'b0, 1'b0, 1'b0);
      f.length = LEN_TCP_END;
      send_frame(f);

      // full handshake on one connection, both directions, then close
      send_frame(frame_for_key(ka, 1'b0, 1'b0, 1'b1, 1'b0));
      send_frame(frame_for_key(ka, 1'b1, 1'b0, 1'b1, 1'b1));
      send_frame(frame_for_key(ka, 1'b0, 1'b0, 1'b0, 1'b1));
      send_frame(frame_for_key(ka, 1'b0, 1'b1, 1'b1, 1'b1));
      // close on an unknown connection creates an empty entry
      send_frame(frame_for_key(kb, 1'b1, 1'b1, 1'b0, 1'b0));
      send_frame(frame_for_key(kb, 1'b0, 1'b0, 1'b1, 1'b0));

      // UDP: short, receive insert, transmit ignored, receive merge
      f = frame_for_key(kc, 1'b0, 1'b0, 1'b0, 1'b0);
      f.length = LEN_UDP_END - 16'd1;
      send_frame(f);
      f.length = LEN_UDP_END;
      send_frame(f);
      send_frame(frame_for_key(kd, 1'b1, 1'b0, 1'b0, 1'b0));
      send_frame(frame_for_key(kc, 1'b0, 1'b1, 1'b1, 1'b1));

      // field extremes
      kedge = '1;
      kedge.proto = PROTO_TCP;
      f = frame_for_key(kedge, 1'b1, 1'b1, 1'b1, 1'b1);
      f.length  = 16'hFFFF;
      f.ingress = 8'hFF;
      send_frame(f);
      kedge = '0;
      kedge.proto = PROTO_TCP;
      f = frame_for_key(kedge, 1'b0, 1'b0, 1'b0, 1'b1);
      f.length  = LEN_TCP_END;
      f.ingress = 8'h00;
      send_frame(f);
      kedge = '1;
      f = frame_for_key(kedge, 1'b1, 1'b1, 1'b1, 1'b1);
      f.length  = 16'hFFFF;
      f.etype   = 16'hFFFF;
      f.ingress = 8'hFF;
      send_frame(f);

      for (int p = 0; p < 3; p++) begin
         drain();
         set_forwarding(phase_fwd[p]);
         sender_idle = phase_idle[p];
         repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(49) == 0) drain();
            send_frame(random_frame());
         end
      end

      drain();
      repeat (SCAN_CYCLES) @(posedge clock);
      if (tracker_model.pending_verdicts.size() != 0)
         tracker_model.report_mismatch($sformatf("%0d results never arrived",
                                                 tracker_model.pending_verdicts.size()));
      $display("Sent %0d frames under %0d forwarding settings, %0d results checked.",
               frames_sent, settings_used, tracker_model.checked);
      $display("Table: %0d inserts, %0d merges, %0d full-table drops, %0d of %0d entries used.",
               tracker_model.inserts, tracker_model.merges, tracker_model.drops,
               tracker_model.used, ENTRIES);
      if (tracker_model.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/ctt_pkg.sv
hw/rtl/ctt_lookup.sv
hw/rtl/tcp_udp_connection_tracker.sv
tb/tcp_udp_connection_tracker_tb.sv
